@@ rtl/aavr_pkg.sv @@
// Shared constants, tables and types for the axis-angle vector rotator.
package aavr_pkg;

    // Angle units: 1/128 degree
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int ONE_Q14      = 16384;

    // mag / 45 by reciprocal: floor(mag * RECIP45 / 2^19) is exact for mag <= 11520
    localparam int MAG_DIV   = 45;
    localparam int RECIP45   = 11651;
    localparam int RECIP_SH  = 19;

    // pi in Q2.30 and the CORDIC start value (inverse gain) in Q2.30
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    // CORDIC datapath widths
    localparam int XY_W = 34;
    localparam int Z_W  = 33;

    localparam int ATAN_ENTRIES = 24;
    typedef logic [31:0] t_atan_tab [0:ATAN_ENTRIES-1];

    localparam t_atan_tab ATAN_Q30 = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Per-remainder terms of round(mag * pi / 23040): (b*pi + 11520) split by 23040
    typedef logic [22:0] t_tq_tab [0:MAG_DIV-1];
    typedef logic [14:0] t_tr_tab [0:MAG_DIV-1];

    function automatic t_tq_tab build_tq();
        t_tq_tab tab;
        longint  num;
        int      b;
        for (b = 0; b < MAG_DIV; b++) begin
            num    = longint'(b) * longint'(PI_Q30) + longint'(QUARTER_TURN);
            tab[b] = 23'(num / HALF_TURN);
        end
        return tab;
    endfunction

    function automatic t_tr_tab build_tr();
        t_tr_tab tab;
        longint  num;
        int      b;
        for (b = 0; b < MAG_DIV; b++) begin
            num    = longint'(b) * longint'(PI_Q30) + longint'(QUARTER_TURN);
            tab[b] = 15'(num % HALF_TURN);
        end
        return tab;
    endfunction

    localparam t_tq_tab TQ_TAB = build_tq();
    localparam t_tr_tab TR_TAB = build_tr();

endpackage

@@ rtl/aavr_cordic_cell.sv @@
// One rotation-mode CORDIC cell: a fixed shift and arctangent, registered output.
module aavr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                             i_clk,
    input  logic signed [aavr_pkg::XY_W-1:0] i_x,
    input  logic signed [aavr_pkg::XY_W-1:0] i_y,
    input  logic signed [aavr_pkg::Z_W-1:0]  i_z,
    output logic signed [aavr_pkg::XY_W-1:0] o_x,
    output logic signed [aavr_pkg::XY_W-1:0] o_y,
    output logic signed [aavr_pkg::Z_W-1:0]  o_z
);
    import aavr_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_Q30[STAGE]);

    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic signed [XY_W-1:0] w_dx, w_dy;

    // micro-rotation toward zero residual angle
    always_comb begin
        w_dx = i_y >>> STAGE;
        w_dy = i_x >>> STAGE;
        if (!i_z[Z_W-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

@@ rtl/axis_angle_vector_rotation.sv @@
// Top level: rotates the look-at point about the eye by an axis and an angle.
// Throughput: one item per cycle; busy stays low, the pipeline runs without stalls.
// The CORDIC chain has one cell per stage, between 4 angle stages and 7 cos/sin, matrix and output stages.
// Reset clears only the valid pipeline; no result strobes after reset until an item enters.
module axis_angle_vector_rotation #(
    parameter int COORD_WIDTH = 24,
    parameter int TRIG_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [16:0]            i_angle_deg,
    input  logic signed [15:0]            i_axis_x,
    input  logic signed [15:0]            i_axis_y,
    input  logic signed [15:0]            i_axis_z,
    input  logic signed [COORD_WIDTH-1:0] i_eye_x,
    input  logic signed [COORD_WIDTH-1:0] i_eye_y,
    input  logic signed [COORD_WIDTH-1:0] i_eye_z,
    input  logic signed [COORD_WIDTH-1:0] i_look_x,
    input  logic signed [COORD_WIDTH-1:0] i_look_y,
    input  logic signed [COORD_WIDTH-1:0] i_look_z,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_new_look_x,
    output logic signed [COORD_WIDTH-1:0] o_new_look_y,
    output logic signed [COORD_WIDTH-1:0] o_new_look_z,
    output logic                          o_saturated
);
    import aavr_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int V_W  = CW + 1;
    localparam int MR_W = 26;
    localparam int M_W  = 52;
    localparam int P_W  = MR_W + V_W;
    localparam int S_W  = P_W + 2;
    localparam int RS_W = S_W - 20;
    localparam int R_W  = RS_W + 1;
    localparam int LAT  = TRIG_STAGES + 11;

    // payload taps read by later stages
    localparam int IX_CS  = TRIG_STAGES + 3;
    localparam int IX_M1  = TRIG_STAGES + 4;
    localparam int IX_PR  = TRIG_STAGES + 7;
    localparam int IX_OUT = TRIG_STAGES + 9;

    localparam logic signed [R_W-1:0] C_HI = R_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0] C_LO = R_W'(-(64'sd1 <<< (CW - 1)));
    localparam logic signed [CW-1:0]  O_HI = CW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [CW-1:0]  O_LO = CW'(-(64'sd1 <<< (CW - 1)));

    typedef struct packed {
        logic                  neg;
        logic [2:0][15:0]      u;
        logic [2:0][CW-1:0]    e;
        logic [2:0][V_W-1:0]   v;
    } t_pay;

    logic   r_vld [0:LAT-1];
    t_pay   r_pay [0:LAT-2];
    t_pay   n_pay;

    assign busy = 1'b0;

    // ---------------- angle reduction and scaling ----------------
    logic signed [17:0] w_red, w_fold;
    logic               w_neg;
    logic [13:0]        n_s1_mag;
    logic [13:0]        r_s1_mag, r_s2_mag;
    logic               r_s1_sgn, r_s2_sgn, r_s3_sgn;
    logic [8:0]         r_s2_q;
    logic [27:0]        w_qprod;
    logic [13:0]        w_rem;
    logic [5:0]         r_s3_b;
    logic [40:0]        r_s3_qp;
    logic [15:0]        w_s;
    logic [31:0]        w_th;
    logic signed [Z_W-1:0] r_s4_z;

    // reduce to [-180, 180) degrees, then fold into [-90, 90]
    always_comb begin
        w_red = 18'(i_angle_deg);
        if (w_red >= 18'(HALF_TURN)) begin
            w_red = w_red - 18'(FULL_TURN);
        end else if (w_red < -18'(HALF_TURN)) begin
            w_red = w_red + 18'(FULL_TURN);
        end
        w_fold = w_red;
        w_neg  = 1'b0;
        if (w_red > 18'(QUARTER_TURN)) begin
            w_fold = w_red - 18'(HALF_TURN);
            w_neg  = 1'b1;
        end else if (w_red < -18'(QUARTER_TURN)) begin
            w_fold = w_red + 18'(HALF_TURN);
            w_neg  = 1'b1;
        end
        n_s1_mag = w_fold[17] ? 14'(-w_fold) : 14'(w_fold);
    end

    // view vector and the payload that rides along
    always_comb begin
        n_pay.neg  = w_neg;
        n_pay.u[0] = i_axis_x;
        n_pay.u[1] = i_axis_y;
        n_pay.u[2] = i_axis_z;
        n_pay.e[0] = i_eye_x;
        n_pay.e[1] = i_eye_y;
        n_pay.e[2] = i_eye_z;
        n_pay.v[0] = V_W'(i_look_x) - V_W'(i_eye_x);
        n_pay.v[1] = V_W'(i_look_y) - V_W'(i_eye_y);
        n_pay.v[2] = V_W'(i_look_z) - V_W'(i_eye_z);
    end

    // mag = 45*q + b; theta = q*pi/512 + (b*pi + 11520)/23040 with exact carry
    assign w_qprod = 28'(r_s1_mag) * 28'(RECIP45);
    assign w_rem   = r_s2_mag - 14'(r_s2_q) * 14'(MAG_DIV);
    assign w_s     = 16'(r_s3_qp[8:0]) * 16'(MAG_DIV) + 16'(TR_TAB[r_s3_b]);
    assign w_th    = r_s3_qp[40:9] + 32'(TQ_TAB[r_s3_b])
                   + 32'(w_s >= 16'(HALF_TURN));

    always_ff @(posedge i_clk) begin
        r_s1_mag <= n_s1_mag;
        r_s1_sgn <= w_fold[17];
        r_s2_q   <= w_qprod[RECIP_SH +: 9];
        r_s2_mag <= r_s1_mag;
        r_s2_sgn <= r_s1_sgn;
        r_s3_b   <= w_rem[5:0];
        r_s3_qp  <= 41'(r_s2_q) * 41'(PI_Q30);
        r_s3_sgn <= r_s2_sgn;
        r_s4_z   <= r_s3_sgn ? -Z_W'(w_th) : Z_W'(w_th);
    end

    // ---------------- CORDIC chain ----------------
    logic signed [XY_W-1:0] w_x [0:TRIG_STAGES];
    logic signed [XY_W-1:0] w_y [0:TRIG_STAGES];
    logic signed [Z_W-1:0]  w_z [0:TRIG_STAGES];

    assign w_x[0] = XY_W'(CORDIC_GAIN);
    assign w_y[0] = '0;
    assign w_z[0] = r_s4_z;

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        aavr_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_x   (w_x[g]),
            .i_y   (w_y[g]),
            .i_z   (w_z[g]),
            .o_x   (w_x[g+1]),
            .o_y   (w_y[g+1]),
            .o_z   (w_z[g+1])
        );
    end

    // ---------------- cos/sin to Q1.14 ----------------
    logic signed [XY_W-1:0] w_xr, w_yr;
    logic signed [15:0]     n_cs_c, n_cs_s, r_cs_c, r_cs_s;

    always_comb begin
        w_xr = (w_x[TRIG_STAGES] + XY_W'(32768)) >>> 16;
        w_yr = (w_y[TRIG_STAGES] + XY_W'(32768)) >>> 16;
        if (w_xr > XY_W'(ONE_Q14)) begin
            n_cs_c = 16'(ONE_Q14);
        end else if (w_xr < -XY_W'(ONE_Q14)) begin
            n_cs_c = -16'(ONE_Q14);
        end else begin
            n_cs_c = w_xr[15:0];
        end
        if (w_yr > XY_W'(ONE_Q14)) begin
            n_cs_s = 16'(ONE_Q14);
        end else if (w_yr < -XY_W'(ONE_Q14)) begin
            n_cs_s = -16'(ONE_Q14);
        end else begin
            n_cs_s = w_yr[15:0];
        end
        if (r_pay[IX_CS].neg) begin
            n_cs_c = -n_cs_c;
            n_cs_s = -n_cs_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cs_c <= n_cs_c;
        r_cs_s <= n_cs_s;
    end

    // ---------------- rotation matrix ----------------
    logic signed [15:0]    w_u [0:2];
    logic signed [31:0]    r_m1_uu [0:2][0:2];
    logic signed [31:0]    r_m1_us [0:2];
    logic signed [17:0]    r_m1_t;
    logic signed [15:0]    r_m1_c, r_m2_c;
    logic signed [49:0]    r_m2_tuu [0:2][0:2];
    logic signed [31:0]    r_m2_us [0:2];
    logic signed [M_W-1:0] w_m [0:2][0:2];
    logic signed [M_W-1:0] w_mr [0:2][0:2];
    logic signed [M_W-1:0] w_sk [0:2][0:2];
    logic signed [MR_W-1:0] r_m3_mr [0:2][0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k] = $signed(r_pay[IX_M1].u[k]);
        end
    end

    // skew-symmetric sine terms: s * [u]x
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                case (3 * i + j)
                    1:       w_sk[i][j] = -(M_W'(r_m2_us[2]) <<< 14);
                    3:       w_sk[i][j] =  (M_W'(r_m2_us[2]) <<< 14);
                    2:       w_sk[i][j] =  (M_W'(r_m2_us[1]) <<< 14);
                    6:       w_sk[i][j] = -(M_W'(r_m2_us[1]) <<< 14);
                    5:       w_sk[i][j] = -(M_W'(r_m2_us[0]) <<< 14);
                    7:       w_sk[i][j] =  (M_W'(r_m2_us[0]) <<< 14);
                    default: w_sk[i][j] = '0;
                endcase
                w_m[i][j] = M_W'(r_m2_tuu[i][j]) + w_sk[i][j];
                if (i == j) begin
                    w_m[i][j] = w_m[i][j] + (M_W'(r_m2_c) <<< 28);
                end
                w_mr[i][j] = (w_m[i][j] + (M_W'(1) <<< 21)) >>> 22;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_m1_us[i] <= 32'(w_u[i]) * 32'(r_cs_s);
            r_m2_us[i] <= r_m1_us[i];
            for (int j = 0; j < 3; j++) begin
                r_m1_uu[i][j]  <= 32'(w_u[i]) * 32'(w_u[j]);
                r_m2_tuu[i][j] <= 50'(r_m1_t) * 50'(r_m1_uu[i][j]);
                r_m3_mr[i][j]  <= w_mr[i][j][MR_W-1:0];
            end
        end
        r_m1_t <= 18'(ONE_Q14) - 18'(r_cs_c);
        r_m1_c <= r_cs_c;
        r_m2_c <= r_m1_c;
    end

    // ---------------- matrix times view vector ----------------
    logic signed [P_W-1:0]  r_pr [0:2][0:2];
    logic signed [S_W-1:0]  w_sum [0:2];
    logic signed [S_W-1:0]  w_rnd [0:2];
    logic signed [RS_W-1:0] r_rs [0:2];
    logic signed [R_W-1:0]  w_res [0:2];
    logic signed [CW-1:0]   n_out [0:2];
    logic [2:0]             w_clip;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = S_W'(r_pr[i][0]) + S_W'(r_pr[i][1]) + S_W'(r_pr[i][2]);
            w_rnd[i] = (w_sum[i] + (S_W'(1) <<< 19)) >>> 20;
        end
    end

    // add the eye back and clip to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_res[i]  = R_W'(r_rs[i]) + R_W'($signed(r_pay[IX_OUT].e[i]));
            w_clip[i] = 1'b0;
            if (w_res[i] > C_HI) begin
                n_out[i]  = O_HI;
                w_clip[i] = 1'b1;
            end else if (w_res[i] < C_LO) begin
                n_out[i]  = O_LO;
                w_clip[i] = 1'b1;
            end else begin
                n_out[i] = w_res[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_pr[i][j] <= P_W'(r_m3_mr[i][j]) * P_W'($signed(r_pay[IX_PR].v[j]));
            end
            r_rs[i] <= w_rnd[i][RS_W-1:0];
        end
        o_new_look_x <= n_out[0];
        o_new_look_y <= n_out[1];
        o_new_look_z <= n_out[2];
        o_saturated  <= |w_clip;
    end

    // ---------------- valid and payload delay line ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay[0] <= n_pay;
        for (int k = 1; k < LAT - 1; k++) begin
            r_pay[k] <= r_pay[k-1];
        end
    end

    assign o_done = r_vld[LAT-1];

`ifndef SYNTHESIS
    // every accepted item comes out with a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result strobe missing after pipeline latency");

    // a clipped result sits on a rail in at least one component
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
            (o_new_look_x == O_HI || o_new_look_x == O_LO ||
             o_new_look_y == O_HI || o_new_look_y == O_LO ||
             o_new_look_z == O_HI || o_new_look_z == O_LO))
        else $error("saturated flag without a clipped component");

    // no strobe right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");
`endif

endmodule

@@ bench/axis_angle_vector_rotation_tb.sv @@
// Self-checking bench for the axis-angle look-at point rotator.
module axis_angle_vector_rotation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aavr_pkg::*;

    localparam int CW = 24;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 11;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        logic signed [16:0]    ang;
        logic signed [15:0]    ax, ay, az;
        logic signed [CW-1:0]  ex, ey, ez, lx, ly, lz;
    } t_rot_item;

    typedef struct {
        logic signed [CW-1:0] nx, ny, nz;
        logic                 sat;
    } t_look;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [16:0] i_angle_deg = '0;
    logic signed [15:0] i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic signed [CW-1:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic signed [CW-1:0] i_look_x = '0, i_look_y = '0, i_look_z = '0;
    logic o_done;
    logic signed [CW-1:0] o_new_look_x, o_new_look_y, o_new_look_z;
    logic o_saturated;

    t_look expected_looks[$];
    int errors = 0;
    int gap_pct = 0;

    axis_angle_vector_rotation #(.COORD_WIDTH(CW), .TRIG_STAGES(STAGES)) dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Sine and cosine in Q1.14 after reduction mod 360 and CORDIC
    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint r, mag, theta, x, y, nx;
        bit neg;
        neg = 0;
        r = ang % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        if (r >= HALF_TURN) r -= FULL_TURN;
        if (r > QUARTER_TURN) begin
            r -= HALF_TURN; neg = 1;
        end else if (r < -QUARTER_TURN) begin
            r += HALF_TURN; neg = 1;
        end
        mag = (r < 0) ? -r : r;
        theta = (mag * longint'(PI_Q30) + QUARTER_TURN) / HALF_TURN;
        if (r < 0) theta = -theta;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            if (theta >= 0) begin
                nx = x - fl_shift(y, i); y = y + fl_shift(x, i);
                theta -= longint'(ATAN_Q30[i]);
            end else begin
                nx = x + fl_shift(y, i); y = y - fl_shift(x, i);
                theta += longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        c = rnd_shift(x, 16);
        s = rnd_shift(y, 16);
        if (c > ONE_Q14) c = ONE_Q14;
        if (c < -ONE_Q14) c = -ONE_Q14;
        if (s > ONE_Q14) s = ONE_Q14;
        if (s < -ONE_Q14) s = -ONE_Q14;
        if (neg) begin
            c = -c; s = -s;
        end
    endfunction

    // New look-at point: E + R*(L - E), saturated
    function automatic t_look rotate_look(t_rot_item it);
        longint u[3], e[3], v[3], m[3][3];
        longint c, s, t, res;
        longint r[3];
        t_look o;
        o.sat = 0;
        u[0] = it.ax; u[1] = it.ay; u[2] = it.az;
        e[0] = it.ex; e[1] = it.ey; e[2] = it.ez;
        v[0] = longint'(it.lx) - e[0];
        v[1] = longint'(it.ly) - e[1];
        v[2] = longint'(it.lz) - e[2];
        sin_cos(longint'(it.ang), c, s);
        t = ONE_Q14 - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = t * u[i] * u[j];
        for (int i = 0; i < 3; i++) m[i][i] += c * (longint'(1) << 28);
        m[0][1] -= u[2] * s * ONE_Q14;
        m[1][0] += u[2] * s * ONE_Q14;
        m[0][2] += u[1] * s * ONE_Q14;
        m[2][0] -= u[1] * s * ONE_Q14;
        m[1][2] -= u[0] * s * ONE_Q14;
        m[2][1] += u[0] * s * ONE_Q14;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = rnd_shift(m[i][j], 22);
        for (int i = 0; i < 3; i++) begin
            res = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
            res = rnd_shift(res, 20) + e[i];
            if (res > longint'(CMAX)) begin
                res = CMAX; o.sat = 1;
            end else if (res < longint'(CMIN)) begin
                res = CMIN; o.sat = 1;
            end
            r[i] = res;
        end
        o.nx = r[0][CW-1:0]; o.ny = r[1][CW-1:0]; o.nz = r[2][CW-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_look w;
        if (i_rst_n && o_done) begin
            if (expected_looks.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = expected_looks.pop_front();
                if (o_new_look_x !== w.nx) report_mismatch("new_look_x", o_new_look_x, w.nx);
                if (o_new_look_y !== w.ny) report_mismatch("new_look_y", o_new_look_y, w.ny);
                if (o_new_look_z !== w.nz) report_mismatch("new_look_z", o_new_look_z, w.nz);
                if (o_saturated !== w.sat) report_mismatch("saturated", o_saturated, w.sat);
            end
        end
    end

    // Send one item; start stays high across back-to-back items
    task automatic send_item(input t_rot_item it);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_angle_deg <= it.ang;
        i_axis_x <= it.ax; i_axis_y <= it.ay; i_axis_z <= it.az;
        i_eye_x <= it.ex; i_eye_y <= it.ey; i_eye_z <= it.ez;
        i_look_x <= it.lx; i_look_y <= it.ly; i_look_z <= it.lz;
        do @(posedge i_clk); while (busy);
        expected_looks.push_back(rotate_look(it));
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return CW'($urandom);
            1: return CW'(int'($urandom_range(65535)) - 32768);
            2: return $urandom_range(1) ? CMAX : CMIN;
            default: return CW'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    // Axis along one coordinate direction, along a unit diagonal, or with random components
    function automatic t_rot_item rand_item();
        t_rot_item it;
        int k;
        k = $urandom_range(9);
        if (k < 3) begin
            it.ax = (k == 0) ? 16384 : 0;
            it.ay = (k == 1) ? 16384 : 0;
            it.az = (k == 2) ? 16384 : 0;
            if ($urandom_range(1)) begin
                it.ax = -it.ax; it.ay = -it.ay; it.az = -it.az;
            end
        end else if (k < 6) begin
            it.ax = 9459; it.ay = -9459; it.az = 9459;
            if ($urandom_range(1)) it.ax = -9459;
            if ($urandom_range(1)) it.az = -9459;
        end else begin
            it.ax = rand_axis(); it.ay = rand_axis(); it.az = rand_axis();
        end
        if ($urandom_range(7) == 0) it.ang = 17'($urandom);
        else it.ang = 17'(int'($urandom_range(92160)) - 46080);
        it.ex = rand_coord(); it.ey = rand_coord(); it.ez = rand_coord();
        it.lx = rand_coord(); it.ly = rand_coord(); it.lz = rand_coord();
        return it;
    endfunction

    task automatic wait_drained();
        while (expected_looks.size() != 0) @(posedge i_clk);
    endtask

    // Directed: angle extremes, axis extremes, saturation, non-unit axes
    task automatic test_directed();
        t_rot_item it;
        int angs[10] = '{0, 11520, -11520, 23040, -23040, 46080, -46080, 65535, -65536, 5760};
        it.ex = 0; it.ey = 0; it.ez = 0;
        it.lx = 4096; it.ly = 8192; it.lz = -4096;
        it.ax = 0; it.ay = 0; it.az = 16384;
        foreach (angs[i]) begin
            it.ang = 17'(angs[i]);
            send_item(it);
        end
        it.ang = 11520;
        it.ax = 16384; it.az = 0; send_item(it);
        it.ax = -16384; send_item(it);
        it.ax = 0; it.ay = -16384; send_item(it);
        it.ax = -1; it.ay = -1; it.az = -1; send_item(it);
        it.ax = 32767; it.ay = -32768; it.az = 32767; send_item(it);
        it.ax = 0; it.ay = 0; it.az = 16384; it.ang = 23040;
        it.ex = CMAX; it.ey = CMIN; it.ez = CMAX;
        it.lx = CMIN; it.ly = CMAX; it.lz = CMIN; send_item(it);
        it.ex = CMAX; it.ey = CMAX; it.ez = CMAX;
        it.lx = CMAX; it.ly = CMAX; it.lz = CMAX; send_item(it);
        it.ex = CMIN; it.ey = CMIN; it.ez = CMIN;
        it.lx = CMIN; it.ly = CMIN; it.lz = CMIN; send_item(it);
        it.ex = -1; it.ey = -1; it.ez = -1;
        it.lx = -1; it.ly = 0; it.lz = 1; it.ang = -1; send_item(it);
        release_start();
        wait_drained();
    endtask

    task automatic test_random(input int count, input int pct);
        gap_pct = pct;
        repeat (count) send_item(rand_item());
        release_start();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 7);
        // hold off until the pipe is empty
        wait_drained();
        test_random(400, 63);
        test_random(400, 0);
        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0 && expected_looks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
